### hdl/chi_pkg.sv
// ----------------------------------------------------------------------------
// chi_pkg: shared constants and types for the cuckoo hash index.
// Holds the default sizes, the result status codes and the operation codes.
// ----------------------------------------------------------------------------
package chi_pkg;

    localparam int unsigned DEF_MAX_BINS      = 16384;
    localparam int unsigned DEF_MAX_ITEMS     = 4096;
    localparam int unsigned DEF_STASH_DEPTH   = 64;
    localparam int unsigned DEF_MAX_ROTATIONS = 64;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 15;

    localparam logic [CFG_INDEX_W-1:0] REG_BIN_COUNT      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HASH_COUNT     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_REINSERT_LIMIT = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_STASH_SLOTS    = 2'd3;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_FIND   = 1'b1;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
    localparam logic [1:0] STATUS_RANGE    = 2'd2;

    function automatic logic [63:0] rotl7(input logic [63:0] w);
        return {w[56:0], w[63:57]};
    endfunction

endpackage

### hdl/cuckoo_hash_index_with_stash_core.sv
// ----------------------------------------------------------------------------
// cuckoo_hash_index_with_stash_core: cuckoo hash index with a stash.
// Derives three bin addresses from a hash, inserts items with an eviction
// chain and a stash, and finds items by hash.
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  in       in_valid/in_ready    op, item_index, hash_low, hash_high
//  out      out_valid/out_ready  found, found_index, location, status
//  cfg      cfg_we               cfg_index, cfg_data
//
// One item at a time. Address reduction rotates each hash word until its masked
// value is in range or MAX_ROTATIONS rotations are done, through a single shared
// rotate and compare unit. An insert stores the addresses, runs placement steps
// (load, address, read, write) and scans stash slots (read, check); a find probes
// bins (address, read, fetch, compare), then stash slots (read, check, compare).
// After reset a clearing pass over the larger of MAX_BINS and STASH_DEPTH entries
// empties the bin table and stash; no item is accepted meanwhile. in_ready is
// low while an item is at work or while its result waits in the output register.
module cuckoo_hash_index_with_stash_core #(
    parameter int unsigned MAX_BINS      = chi_pkg::DEF_MAX_BINS,
    parameter int unsigned MAX_ITEMS     = chi_pkg::DEF_MAX_ITEMS,
    parameter int unsigned STASH_DEPTH   = chi_pkg::DEF_STASH_DEPTH,
    parameter int unsigned MAX_ROTATIONS = chi_pkg::DEF_MAX_ROTATIONS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [chi_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [chi_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            op,
    input  logic [11:0]                     item_index,
    input  logic [63:0]                     hash_low,
    input  logic [63:0]                     hash_high,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            found,
    output logic [11:0]                     found_index,
    output logic [14:0]                     location,
    output logic [1:0]                      status
);
    import chi_pkg::*;

    localparam int unsigned BA_W  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int unsigned IT_W  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int unsigned SD_W  = (STASH_DEPTH > 1) ? $clog2(STASH_DEPTH) : 1;
    localparam int unsigned SC_W  = $clog2(STASH_DEPTH + 1);
    localparam int unsigned RT_W  = $clog2(MAX_ROTATIONS + 1);
    localparam int unsigned BC_W  = $clog2(MAX_BINS + 1);
    localparam int unsigned ENT_W = 1 + IT_W + 2;
    localparam int unsigned CL_N  = (MAX_BINS > STASH_DEPTH) ? MAX_BINS : STASH_DEPTH;
    localparam int unsigned CL_W  = (CL_N > 1) ? $clog2(CL_N) : 1;

    typedef enum logic [18:0] {
        S_CLEAR  = 19'h00001,
        S_IDLE   = 19'h00002,
        S_RED    = 19'h00004,
        S_STORE  = 19'h00008,
        S_PLOAD  = 19'h00010,
        S_PADDR  = 19'h00020,
        S_PREAD  = 19'h00040,
        S_PWRITE = 19'h00080,
        S_SREAD  = 19'h00100,
        S_SSCAN  = 19'h00200,
        S_FBIN   = 19'h00400,
        S_FBRD   = 19'h00800,
        S_FBADR  = 19'h01000,
        S_FBCMP  = 19'h02000,
        S_FSREAD = 19'h04000,
        S_FSTASH = 19'h08000,
        S_FSCMP  = 19'h10000,
        S_DONE   = 19'h20000,
        S_OUT    = 19'h40000
    } state_t;

    state_t state_reg, state_next;

    logic [14:0] bin_count_reg;
    logic [1:0]  hash_count_reg;
    logic [9:0]  reinsert_limit_reg;
    logic [6:0]  stash_slots_reg;

    logic [ENT_W-1:0]  bin_mem [MAX_BINS];
    logic [ENT_W-1:0]  bin_rd_reg;
    logic [3*BA_W-1:0] addr_mem [MAX_ITEMS];
    logic [3*BA_W-1:0] addr_rd_reg;
    logic [ENT_W-1:0]  stash_mem [STASH_DEPTH];
    logic [ENT_W-1:0]  stash_rd_reg;

    logic              op_reg;
    logic [IT_W-1:0]   item_reg;
    logic [63:0]       word_reg [3];
    logic [1:0]        wsel_reg;
    logic [RT_W-1:0]   rot_reg;
    logic [BA_W-1:0]   a_reg [3];
    logic              range_bad_reg;
    logic [1:0]        choice_reg;
    logic [9:0]        tries_reg;
    logic [SC_W-1:0]   sidx_reg;
    logic [1:0]        probe_reg;
    logic [CL_W-1:0]   clr_reg;
    logic [BA_W-1:0]   paddr_reg;
    logic              res_found_reg;
    logic [IT_W-1:0]   res_idx_reg;
    logic [14:0]       res_loc_reg;
    logic [1:0]        res_status_reg;

    logic [BC_W-1:0] eff_bins;
    logic [1:0]      eff_hashes;
    logic [SC_W-1:0] eff_stash;
    logic [BC_W-1:0] mask;
    logic [63:0]     cur_word;
    logic [BC_W-1:0] masked;
    logic            in_range;
    logic            match_bin;
    logic            match_stash;
    logic [IT_W-1:0] rd_item;
    logic [2:0]      choice_inc;
    logic [1:0]      next_choice;

    always_comb
    begin
        eff_bins = (bin_count_reg == 15'd0) ? BC_W'(1) :
                   ({17'd0, bin_count_reg} > 32'(MAX_BINS)) ? BC_W'(MAX_BINS) :
                   BC_W'(bin_count_reg);
        eff_hashes = (hash_count_reg == 2'd3) ? 2'd3 : 2'd2;
        eff_stash = ({25'd0, stash_slots_reg} > 32'(STASH_DEPTH)) ? SC_W'(STASH_DEPTH) :
                    SC_W'(stash_slots_reg);
        mask = '0;
        for (int b = BC_W - 1; b >= 0; b--)
        begin
            if (mask == '0 && eff_bins > 1 && b < BC_W - 1
                && ((BC_W'(1) << b) < eff_bins)
                && ((BC_W'(1) << (b + 1)) >= eff_bins))
            begin
                mask = (BC_W'(1) << (b + 1)) - BC_W'(1);
            end
        end
        cur_word = word_reg[wsel_reg];
        masked = cur_word[BC_W-1:0] & mask;
        in_range = masked < eff_bins;
        match_bin = bin_rd_reg[ENT_W-1]
                    && addr_rd_reg == {a_reg[2], a_reg[1], a_reg[0]};
        match_stash = addr_rd_reg == {a_reg[2], a_reg[1], a_reg[0]};
        if (state_reg == S_FBADR)
            rd_item = bin_rd_reg[ENT_W-2 -: IT_W];
        else if (state_reg == S_FSTASH)
            rd_item = stash_rd_reg[ENT_W-2 -: IT_W];
        else
            rd_item = item_reg;
        choice_inc = {1'b0, bin_rd_reg[1:0]} + 3'd1;
        next_choice = (choice_inc >= {1'b0, eff_hashes}) ?
                      2'(choice_inc - {1'b0, eff_hashes}) : 2'(choice_inc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_count_reg      <= 15'd16384;
            hash_count_reg     <= 2'd3;
            reinsert_limit_reg <= 10'd100;
            stash_slots_reg    <= 7'd8;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BIN_COUNT:      bin_count_reg      <= cfg_data;
                REG_HASH_COUNT:     hash_count_reg     <= cfg_data[1:0];
                REG_REINSERT_LIMIT: reinsert_limit_reg <= cfg_data[9:0];
                REG_STASH_SLOTS:    stash_slots_reg    <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:  if (clr_reg == CL_W'(CL_N - 1)) state_next = S_IDLE;
            S_IDLE:   if (in_valid) state_next = S_RED;
            S_RED:
            begin
                if (wsel_reg == 2'd2 && (in_range || rot_reg == RT_W'(MAX_ROTATIONS)))
                    state_next = (range_bad_reg || !in_range) ? S_DONE :
                                 (op_reg == OP_INSERT) ? S_STORE : S_FBIN;
            end
            S_STORE:  state_next = S_PLOAD;
            S_PLOAD:  state_next = S_PADDR;
            S_PADDR:  state_next = S_PREAD;
            S_PREAD:  state_next = S_PWRITE;
            S_PWRITE:
            begin
                if (!bin_rd_reg[ENT_W-1]) state_next = S_DONE;
                else if (tries_reg != reinsert_limit_reg) state_next = S_PLOAD;
                else state_next = S_SREAD;
            end
            S_SREAD:  state_next = S_SSCAN;
            S_SSCAN:
            begin
                if (sidx_reg >= eff_stash || !stash_rd_reg[ENT_W-1]) state_next = S_DONE;
                else state_next = S_SREAD;
            end
            S_FBIN:   state_next = S_FBRD;
            S_FBRD:   state_next = S_FBADR;
            S_FBADR:  state_next = S_FBCMP;
            S_FBCMP:
            begin
                if (match_bin) state_next = S_DONE;
                else if (probe_reg + 2'd1 == eff_hashes) state_next = S_FSREAD;
                else state_next = S_FBIN;
            end
            S_FSREAD: state_next = S_FSTASH;
            S_FSTASH:
            begin
                if (sidx_reg >= eff_stash || !stash_rd_reg[ENT_W-1]) state_next = S_DONE;
                else state_next = S_FSCMP;
            end
            S_FSCMP:  state_next = match_stash ? S_DONE : S_FSREAD;
            S_DONE:   state_next = S_OUT;
            S_OUT:    if (out_ready) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR) clr_reg <= clr_reg + CL_W'(1);
        end
    end

    // Memories: bin table, item address store, stash.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_CLEAR)
        begin
            if (32'(clr_reg) < MAX_BINS)
                bin_mem[BA_W'(clr_reg)] <= '0;
        end
        else if (state_reg == S_PWRITE)
            bin_mem[paddr_reg] <= {1'b1, item_reg, choice_reg};
        bin_rd_reg <= bin_mem[paddr_reg];
        if (state_reg == S_STORE)
            addr_mem[item_reg] <= {a_reg[2], a_reg[1], a_reg[0]};
        addr_rd_reg <= addr_mem[rd_item];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_CLEAR)
        begin
            if (32'(clr_reg) < STASH_DEPTH)
                stash_mem[SD_W'(clr_reg)] <= '0;
        end
        else if (state_reg == S_SSCAN && sidx_reg < eff_stash && !stash_rd_reg[ENT_W-1])
            stash_mem[sidx_reg[SD_W-1:0]] <= {1'b1, item_reg, choice_reg};
        stash_rd_reg <= stash_mem[sidx_reg[SD_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                op_reg        <= op;
                item_reg      <= IT_W'(item_index);
                word_reg[0]   <= hash_low;
                word_reg[1]   <= {hash_high[31:0], hash_low[63:32]};
                word_reg[2]   <= hash_high;
                wsel_reg      <= 2'd0;
                rot_reg       <= '0;
                range_bad_reg <= 1'b0;
                choice_reg    <= 2'd0;
                tries_reg     <= '0;
                sidx_reg      <= '0;
                probe_reg     <= 2'd0;
                res_found_reg <= 1'b0;
                res_idx_reg   <= '0;
                res_loc_reg   <= '0;
                res_status_reg <= STATUS_OK;
            end
            S_RED:
            begin
                if (in_range || rot_reg == RT_W'(MAX_ROTATIONS))
                begin
                    a_reg[wsel_reg] <= BA_W'(masked);
                    if (!in_range)
                    begin
                        range_bad_reg  <= 1'b1;
                        res_status_reg <= STATUS_RANGE;
                    end
                    wsel_reg <= wsel_reg + 2'd1;
                    rot_reg  <= '0;
                end
                else
                begin
                    word_reg[wsel_reg] <= rotl7(cur_word);
                    rot_reg <= rot_reg + RT_W'(1);
                end
            end
            S_PADDR:
            begin
                paddr_reg <= addr_rd_reg[choice_reg * BA_W +: BA_W];
            end
            S_PWRITE:
            begin
                item_reg   <= bin_rd_reg[ENT_W-2 -: IT_W];
                choice_reg <= bin_rd_reg[1:0];
                if (tries_reg != reinsert_limit_reg)
                begin
                    tries_reg  <= tries_reg + 10'd1;
                    choice_reg <= next_choice;
                end
            end
            S_SSCAN:
            begin
                if (sidx_reg >= eff_stash) res_status_reg <= STATUS_OVERFLOW;
                else sidx_reg <= sidx_reg + SC_W'(1);
            end
            S_FBIN:
            begin
                paddr_reg <= a_reg[probe_reg];
            end
            S_FBCMP:
            begin
                if (match_bin)
                begin
                    res_found_reg <= 1'b1;
                    res_idx_reg   <= bin_rd_reg[ENT_W-2 -: IT_W];
                    res_loc_reg   <= 15'(a_reg[probe_reg]);
                end
                probe_reg <= probe_reg + 2'd1;
            end
            S_FSCMP:
            begin
                if (match_stash)
                begin
                    res_found_reg <= 1'b1;
                    res_idx_reg   <= stash_rd_reg[ENT_W-2 -: IT_W];
                    res_loc_reg   <= 15'(eff_bins) + 15'(sidx_reg);
                end
                else sidx_reg <= sidx_reg + SC_W'(1);
            end
            default: ;
        endcase
    end

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = (state_reg == S_OUT);
    assign found       = res_found_reg;
    assign found_index = 12'(res_idx_reg);
    assign location    = res_loc_reg;
    assign status      = res_status_reg;

endmodule

### hdl/chi_checker.sv
// ----------------------------------------------------------------------------
// chi_checker: port-level checks for the cuckoo hash index.
// Watches handshakes and result codes on the top level's ports.
// ----------------------------------------------------------------------------
module chi_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        found,
    input logic [14:0] location,
    input logic [1:0]  status
);
    import chi_pkg::*;

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("input taken while result pending");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result withdrawn");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status != 2'd3) else $error("bad status");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found |-> status == STATUS_OK) else $error("found with error");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> location == 15'd0) else $error("miss with location");

endmodule

bind cuckoo_hash_index_with_stash_core chi_checker u_chi_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .found(found),
    .location(location), .status(status)
);

### tb/cuckoo_hash_index_with_stash_core_tb.sv
// ----------------------------------------------------------------------------
// Testbench for the cuckoo hash index with stash
// Drives inserts and finds through a random-gap driver, predicts every result
// with a behavioural copy of the bin table, stash and address store, and
// checks each result field by field across several register settings.
// ----------------------------------------------------------------------------
module cuckoo_hash_index_with_stash_core_tb;
    import chi_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NBINS = 16384;
    localparam int NITEMS = 4096;
    localparam int NSTASH = 64;
    localparam int NROT = 64;
    localparam longint CYCLE_LIMIT = 20000000;

    typedef struct packed {
        logic        op;
        logic [11:0] idx;
        logic [63:0] lo;
        logic [63:0] hi;
    } req_t;

    typedef struct packed {
        logic        found;
        logic [11:0] fidx;
        logic [14:0] loc;
        logic [1:0]  status;
    } res_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic op;
    logic [11:0] item_index;
    logic [63:0] hash_low;
    logic [63:0] hash_high;
    logic out_valid;
    logic out_ready;
    logic found;
    logic [11:0] found_index;
    logic [14:0] location;
    logic [1:0] status;

    cuckoo_hash_index_with_stash_core dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .op(op), .item_index(item_index), .hash_low(hash_low), .hash_high(hash_high),
        .out_valid(out_valid), .out_ready(out_ready),
        .found(found), .found_index(found_index), .location(location), .status(status)
    );

    int unsigned bins_reg;
    int unsigned hashes_reg;
    int unsigned limit_reg;
    int unsigned stash_reg;

    bit bin_used [NBINS];
    int unsigned bin_item [NBINS];
    int unsigned bin_choice [NBINS];
    bit stash_used [NSTASH];
    int unsigned stash_item [NSTASH];
    int unsigned stash_choice [NSTASH];
    int unsigned addr_store [NITEMS][3];

    req_t pending_items[$];
    res_t expected_results[$];
    logic [127:0] inserted_hashes[$];
    int errors;
    int gap;
    int hold;
    int results_seen;
    bit long_hold_done;
    longint cycles;

    function automatic int unsigned eff_bins();
        if (bins_reg == 0) return 1;
        if (bins_reg > NBINS) return NBINS;
        return bins_reg;
    endfunction

    function automatic int unsigned eff_hashes();
        if (hashes_reg < 2) return 2;
        if (hashes_reg > 3) return 3;
        return hashes_reg;
    endfunction

    function automatic bit reduce_word(logic [63:0] w, int unsigned nb, logic [63:0] mask,
                                       output int unsigned a);
        a = 0;
        for (int n = 0; n <= NROT; n++) begin
            if ((w & mask) < nb) begin
                a = int'(w & mask);
                return 1;
            end
            w = {w[56:0], w[63:57]};
        end
        return 0;
    endfunction

    function automatic bit bin_addresses(logic [63:0] lo, logic [63:0] hi,
                                         output int unsigned a [3]);
        int unsigned nb;
        logic [63:0] p;
        bit ok0, ok1, ok2;
        nb = eff_bins();
        p = 1;
        while (p < nb) p = p << 1;
        ok0 = reduce_word(lo, nb, p - 1, a[0]);
        ok1 = reduce_word({hi[31:0], lo[63:32]}, nb, p - 1, a[1]);
        ok2 = reduce_word(hi, nb, p - 1, a[2]);
        return ok0 && ok1 && ok2;
    endfunction

    function automatic bit item_matches(int unsigned it, int unsigned a [3]);
        return addr_store[it][0] == a[0] && addr_store[it][1] == a[1]
            && addr_store[it][2] == a[2];
    endfunction

    function automatic bit cuckoo_place(int unsigned it, int unsigned ch);
        int unsigned tries;
        int unsigned ad;
        int unsigned oi, oc;
        bit ov;
        tries = 0;
        forever begin
            ad = addr_store[it][ch % 3] % NBINS;
            ov = bin_used[ad];
            oi = bin_item[ad];
            oc = bin_choice[ad];
            bin_used[ad] = 1;
            bin_item[ad] = it;
            bin_choice[ad] = ch;
            if (!ov) return 1;
            it = oi;
            ch = oc;
            if (tries != limit_reg) begin
                ch = (ch + 1) % eff_hashes();
                tries++;
            end else begin
                for (int k = 0; k < ((stash_reg > NSTASH) ? NSTASH : stash_reg); k++) begin
                    if (!stash_used[k]) begin
                        stash_used[k] = 1;
                        stash_item[k] = it;
                        stash_choice[k] = ch;
                        return 1;
                    end
                end
                return 0;
            end
        end
    endfunction

    function automatic res_t index_result(req_t r);
        res_t e;
        int unsigned a [3];
        int unsigned ns;
        e = '0;
        if (!bin_addresses(r.lo, r.hi, a)) begin
            e.status = STATUS_RANGE;
        end else if (r.op == OP_INSERT) begin
            addr_store[r.idx] = a;
            if (!cuckoo_place(r.idx, 0)) e.status = STATUS_OVERFLOW;
        end else begin
            ns = (stash_reg > NSTASH) ? NSTASH : stash_reg;
            for (int i = 0; i < eff_hashes() && !e.found; i++) begin
                if (bin_used[a[i] % NBINS] && item_matches(bin_item[a[i] % NBINS], a)) begin
                    e.found = 1;
                    e.fidx = 12'(bin_item[a[i] % NBINS]);
                    e.loc = 15'(a[i]);
                end
            end
            for (int i = 0; i < ns && !e.found && stash_used[i]; i++) begin
                if (item_matches(stash_item[i], a)) begin
                    e.found = 1;
                    e.fidx = 12'(stash_item[i]);
                    e.loc = 15'(eff_bins() + i);
                end
            end
        end
        return e;
    endfunction

    function automatic int short_or_long_gap();
        if ($urandom_range(0, 3) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        return $urandom_range(0, 3);
    endfunction

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_results.push_back(index_result({op, item_index, hash_low, hash_high}));
            end
            if (!in_valid || in_ready)
            begin
                if (gap > 0)
                begin
                    gap <= gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_items.size() > 0)
                begin
                    req_t r;
                    r = pending_items.pop_front();
                    op <= r.op;
                    item_index <= r.idx;
                    hash_low <= r.lo;
                    hash_high <= r.hi;
                    in_valid <= 1'b1;
                    gap <= short_or_long_gap();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold <= 0;
            long_hold_done <= 1'b0;
        end
        else if (!long_hold_done && results_seen >= 120)
        begin
            long_hold_done <= 1'b1;
            out_ready <= 1'b0;
            hold <= 300;
        end
        else if (hold > 0)
        begin
            hold <= hold - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            hold <= short_or_long_gap();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            results_seen <= results_seen + 1;
            if (expected_results.size() == 0)
            begin
                $error("unexpected result item");
                errors++;
            end
            else
            begin
                res_t e;
                e = expected_results.pop_front();
                if (found !== e.found)
                begin
                    $error("found: expected %0d, actual %0d", e.found, found);
                    errors++;
                end
                if (found_index !== e.fidx)
                begin
                    $error("found_index: expected %0d, actual %0d", e.fidx, found_index);
                    errors++;
                end
                if (location !== e.loc)
                begin
                    $error("location: expected %0d, actual %0d", e.loc, location);
                    errors++;
                end
                if (status !== e.status)
                begin
                    $error("status: expected %0d, actual %0d", e.status, status);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("cuckoo_hash_index_with_stash_core_tb NOT OK");
            $finish;
        end
    end

    task automatic wait_idle();
        while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
            @(negedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] ix, int unsigned v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= ix;
        cfg_data <= v[CFG_DATA_W-1:0];
        case (ix)
            REG_BIN_COUNT: bins_reg = v & 32'h7fff;
            REG_HASH_COUNT: hashes_reg = v & 32'h3;
            REG_REINSERT_LIMIT: limit_reg = v & 32'h3ff;
            default: stash_reg = v & 32'h7f;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_regs(int unsigned b, int unsigned h, int unsigned l, int unsigned s);
        wait_idle();
        write_reg(REG_BIN_COUNT, b);
        write_reg(REG_HASH_COUNT, h);
        write_reg(REG_REINSERT_LIMIT, l);
        write_reg(REG_STASH_SLOTS, s);
    endtask

    task automatic add_item(logic o, logic [11:0] ix, logic [63:0] lo, logic [63:0] hi);
        pending_items.push_back({o, ix, lo, hi});
        if (o == OP_INSERT) inserted_hashes.push_back({hi, lo});
    endtask

    task automatic add_random_items(int n);
        logic [127:0] h;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 1) == 0 || inserted_hashes.size() == 0)
            begin
                add_item(OP_INSERT, 12'($urandom_range(0, 4095)),
                         {$urandom, $urandom}, {$urandom, $urandom});
            end
            else if ($urandom_range(0, 9) < 7)
            begin
                h = inserted_hashes[$urandom_range(0, inserted_hashes.size() - 1)];
                add_item(OP_FIND, 12'($urandom_range(0, 4095)), h[63:0], h[127:64]);
            end
            else
            begin
                add_item(OP_FIND, 12'($urandom_range(0, 4095)),
                         {$urandom, $urandom}, {$urandom, $urandom});
            end
        end
    endtask

    initial
    begin
        errors = 0;
        cycles = 0;
        results_seen = 0;
        bins_reg = 16384;
        hashes_reg = 3;
        limit_reg = 100;
        stash_reg = 8;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        op = OP_INSERT;
        item_index = '0;
        hash_low = '0;
        hash_high = '0;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        add_item(OP_INSERT, 12'd0, 64'd0, 64'd0);
        add_item(OP_FIND, 12'd0, 64'd0, 64'd0);
        add_item(OP_INSERT, 12'd4095, '1, '1);
        add_item(OP_FIND, 12'd7, '1, '1);
        add_item(OP_FIND, 12'd0, 64'h1234_5678_9abc_def0, 64'h0fed_cba9_8765_4321);
        add_item(OP_INSERT, 12'd4095, 64'h5555_aaaa_5555_aaaa, 64'haaaa_5555_aaaa_5555);
        add_item(OP_FIND, 12'd0, 64'h5555_aaaa_5555_aaaa, 64'haaaa_5555_aaaa_5555);
        add_item(OP_FIND, 12'd0, '1, '1);

        set_regs(3, 2, 0, 2);
        add_item(OP_INSERT, 12'd1, '1, '1);
        add_item(OP_FIND, 12'd1, '1, '1);
        for (int i = 0; i < 7; i++)
            add_item(OP_INSERT, 12'(10 + i), 64'(i * 5), 64'(i * 3 + 1));
        for (int i = 0; i < 7; i++)
            add_item(OP_FIND, 12'd0, 64'(i * 5), 64'(i * 3 + 1));

        set_regs(0, 0, 1023, 0);
        add_item(OP_INSERT, 12'd20, 64'd9, 64'd9);
        add_item(OP_INSERT, 12'd21, 64'd8, 64'd8);
        add_item(OP_FIND, 12'd0, 64'd9, 64'd9);

        set_regs(32767, 3, 0, 127);
        add_random_items(40);

        for (int ph = 0; ph < 6; ph++)
        begin
            set_regs(($urandom_range(0, 9) < 7) ? $urandom_range(1, 40)
                                               : $urandom_range(0, 32767),
                     $urandom_range(0, 3),
                     ($urandom_range(0, 9) < 8) ? $urandom_range(0, 20)
                                               : $urandom_range(0, 1023),
                     ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127)
                                                : $urandom_range(0, 10));
            add_random_items(65);
        end

        set_regs(16384, 3, 100, 64);
        add_random_items(20);

        wait_idle();
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("cuckoo_hash_index_with_stash_core_tb OK");
        else
            $display("cuckoo_hash_index_with_stash_core_tb NOT OK");
        $finish;
    end

endmodule
